// File: hw/rtl/pmsa_pkg.sv
package pmsa_pkg;

  // configuration register indexes (address bit 2)
  localparam logic REG_CURRENT_LSB = 1'b0;
  localparam logic REG_OFFSET      = 1'b1;

  // reset values of the configuration registers
  localparam logic [19:0] CURRENT_LSB_RESET = 20'd100000;
  localparam logic [30:0] OFFSET_RESET      = 31'd0;

  // gain range codes
  localparam logic [1:0] RANGE_40MV  = 2'd0;
  localparam logic [1:0] RANGE_80MV  = 2'd1;
  localparam logic [1:0] RANGE_160MV = 2'd2;
  localparam logic [1:0] RANGE_320MV = 2'd3;

  // shunt magnitude thresholds in 10 uV units
  localparam logic [15:0] UP_FULL       = 16'd15000;
  localparam logic [15:0] UP_TO_160     = 16'd7500;
  localparam logic [15:0] UP_TO_80      = 16'd3800;
  localparam logic [15:0] DOWN_FROM_320 = 16'd12000;
  localparam logic [15:0] DOWN_FROM_160 = 16'd6000;
  localparam logic [15:0] DOWN_FROM_80  = 16'd3000;

  // nA times mV to uW
  localparam logic [20:0] POWER_DIVISOR = 21'd1000000;

  // current saturation value
  localparam logic [34:0] CURRENT_MAX = {35{1'b1}};

  // serial step counts
  localparam int CUR_BITS = 16;
  localparam int BUS_BITS = 15;
  localparam int QUO_BITS = 31;

endpackage

// File: hw/rtl/power_monitor_scale_autorange.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------------------
// input     | in_valid / in_ready           | bus_raw, shunt_raw, current_raw
// output    | out_valid / out_ready         | overflow, bus_mv, shunt_10uv, current_na,
//           |                               | power_uw, gain_range, gain_changed
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// a transaction runs through the current multiply, the offset step, the power multiply, the
// divider load, the divide and the finish state; a new input is taken once the result is loaded
// the bit-serial current multiply has 16 steps, the bit-serial power multiply 15 steps
// and the restoring divide by one million 31 steps
// a result waiting at the output does not hold up the next input; only the final
// result load waits for the output register to free up
// rst is synchronous: the gain range returns to 320 mV and the registers to their defaults
module power_monitor_scale_autorange import pmsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        bus_raw,
  input  logic signed [15:0] shunt_raw,
  input  logic signed [15:0] current_raw,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               overflow,
  output logic [14:0]        bus_mv,
  output logic signed [15:0] shunt_10uv,
  output logic [34:0]        current_na,
  output logic [30:0]        power_uw,
  output logic [1:0]         gain_range,
  output logic               gain_changed,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_CUR,
    S_OFFSET,
    S_MUL_PWR,
    S_DIV_LOAD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t      state;
  logic [4:0]  cnt;

  logic [19:0] current_lsb_na;
  logic [30:0] offset_na;
  logic [1:0]  gain_state;

  // per-transaction holding registers
  logic [15:0] cur_shift;
  logic [14:0] bus_shift;
  logic        hold_ovf;
  logic [14:0] hold_bus_mv;
  logic [15:0] hold_shunt;
  logic [1:0]  hold_range;
  logic        hold_changed;

  // datapath registers
  logic [36:0] acc;
  logic [34:0] cur;
  logic [49:0] prod;
  logic [19:0] rem;

  logic [36:0] acc_next;
  logic [36:0] acc_off;
  logic [34:0] cur_next;
  logic [49:0] prod_next;
  logic [20:0] div_trial;
  logic        div_ge;
  logic [19:0] rem_next;
  logic [15:0] shunt_mag;
  logic [1:0]  range_next;
  logic        in_fire;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_lsb_na <= CURRENT_LSB_RESET;
      offset_na      <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CURRENT_LSB: current_lsb_na <= pwdata[19:0];
        REG_OFFSET:      offset_na      <= pwdata[30:0];
        default:         ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_CURRENT_LSB: prdata = {12'd0, current_lsb_na};
      REG_OFFSET:      prdata = {offset_na[30], offset_na};
      default:         prdata = '0;
    endcase
  end

  // gain range decision on the incoming sample
  always_comb begin
    shunt_mag  = shunt_raw[15] ? (~unsigned'(shunt_raw) + 16'd1) : unsigned'(shunt_raw);
    range_next = gain_state;
    if (bus_raw[0] || shunt_mag > UP_FULL) begin
      range_next = RANGE_320MV;
    end else if (shunt_mag > UP_TO_160 && gain_state < RANGE_160MV) begin
      range_next = RANGE_160MV;
    end else if (shunt_mag > UP_TO_80 && gain_state < RANGE_80MV) begin
      range_next = RANGE_80MV;
    end
    if (!bus_raw[0]) begin
      if (gain_state == RANGE_320MV && shunt_mag < DOWN_FROM_320) begin
        range_next = RANGE_160MV;
      end else if (gain_state == RANGE_160MV && shunt_mag < DOWN_FROM_160) begin
        range_next = RANGE_80MV;
      end else if (gain_state == RANGE_80MV && shunt_mag < DOWN_FROM_80) begin
        range_next = RANGE_40MV;
      end
    end
  end

  // current multiply step, msb first; the sign bit carries negative weight
  always_comb begin
    logic [36:0] addend;
    addend = cur_shift[15] ? {17'd0, current_lsb_na} : 37'd0;
    if (cnt == 5'd0) begin
      acc_next = 37'd0 - addend;
    end else begin
      acc_next = {acc[35:0], 1'b0} + addend;
    end
  end

  // offset subtract and clamp to the 35-bit range
  always_comb begin
    acc_off = acc - {{6{offset_na[30]}}, offset_na};
    if (acc_off[36]) begin
      cur_next = '0;
    end else if (acc_off[35]) begin
      cur_next = CURRENT_MAX;
    end else begin
      cur_next = acc_off[34:0];
    end
  end

  // power multiply step, msb first over the bus voltage bits
  assign prod_next = {prod[48:0], 1'b0} + (bus_shift[14] ? {15'd0, cur} : 50'd0);

  // restoring divide step, one quotient bit per cycle
  assign div_trial = {rem, prod[30]};
  assign div_ge    = (div_trial >= POWER_DIVISOR);
  always_comb begin
    logic [20:0] diff;
    diff     = div_trial - POWER_DIVISOR;
    rem_next = div_ge ? diff[19:0] : div_trial[19:0];
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      gain_state <= RANGE_320MV;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_shift    <= unsigned'(current_raw);
            bus_shift    <= {bus_raw[15:3], 2'b00};
            hold_ovf     <= bus_raw[0];
            hold_bus_mv  <= {bus_raw[15:3], 2'b00};
            hold_shunt   <= unsigned'(shunt_raw);
            hold_range   <= range_next;
            hold_changed <= (range_next != gain_state);
            gain_state   <= range_next;
            cnt          <= '0;
            state        <= S_MUL_CUR;
          end
        end
        S_MUL_CUR: begin
          acc       <= acc_next;
          cur_shift <= {cur_shift[14:0], 1'b0};
          if (cnt == 5'(CUR_BITS - 1)) begin
            cnt   <= '0;
            state <= S_OFFSET;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_OFFSET: begin
          cur   <= cur_next;
          prod  <= '0;
          state <= S_MUL_PWR;
        end
        S_MUL_PWR: begin
          prod      <= prod_next;
          bus_shift <= {bus_shift[13:0], 1'b0};
          if (cnt == 5'(BUS_BITS - 1)) begin
            cnt   <= '0;
            state <= S_DIV_LOAD;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_DIV_LOAD: begin
          // upper product bits sit below the divisor, so their quotient bits are zero
          rem   <= {1'b0, prod[49:31]};
          state <= S_DIV;
        end
        S_DIV: begin
          rem         <= rem_next;
          prod[30:0]  <= {prod[29:0], div_ge};
          if (cnt == 5'(QUO_BITS - 1)) begin
            cnt   <= '0;
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            overflow     <= hold_ovf;
            bus_mv       <= hold_bus_mv;
            shunt_10uv   <= signed'(hold_shunt);
            current_na   <= cur;
            power_uw     <= prod[30:0];
            gain_range   <= hold_range;
            gain_changed <= hold_changed;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // divider remainder always stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> {1'b0, rem} < POWER_DIVISOR)
    else $error("divider remainder out of range");

  // gain range only moves on an accepted input
  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(gain_state))
    else $error("gain range changed without an input transaction");

  // a result reports a change exactly when the range differs from before
  a_gain_flag: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> hold_changed == (gain_state != $past(gain_state)))
    else $error("gain change flag inconsistent with range update");

endmodule
